/* hdl/kthtrk_pkg.sv */
// ----------------------------------------------------------------------------
// kthtrk_pkg
// Shared types and constants of the k-th rank stream tracker.
// ----------------------------------------------------------------------------
package kthtrk_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int SAMPLE_W     = 32;
  localparam int KCOUNT_W     = 11;
  localparam int HELD_W       = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = KCOUNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_K_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 1'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [HELD_W-1:0]          held_t;

endpackage

/* hdl/kthtrk_sample_if.sv */
// ----------------------------------------------------------------------------
// kthtrk_sample_if
// Input channel: one signed stream sample per transaction.
// ----------------------------------------------------------------------------
interface kthtrk_sample_if;
  import kthtrk_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

/* hdl/kthtrk_result_if.sv */
// ----------------------------------------------------------------------------
// kthtrk_result_if
// Result channel: heap root and held count per transaction.
// ----------------------------------------------------------------------------
interface kthtrk_result_if;
  import kthtrk_pkg::*;

  logic    valid;
  logic    ready;
  sample_t rank_value;
  held_t   held_count;

  modport source (output valid, output rank_value, output held_count, input ready);
  modport sink (input valid, input rank_value, input held_count, output ready);
endinterface

/* hdl/kth_largest_stream_tracker_core.sv */
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker_core
// Streaming k-th largest / k-th smallest tracker built on a binary heap.
// ----------------------------------------------------------------------------
// Samples arrive on the sample channel; each transaction yields exactly one
// result transaction carrying the heap root (the k-th best sample so far)
// and the number of samples held. k_count and order_mode are written through
// the cfg_write / cfg_index / cfg_data port; the user must write them only
// while the block is idle, which the block itself does not enforce. The heap
// lives in a two-read, one-write RAM with registered read data. A sample is
// handled in steps: accept, then per heap level walked a read and a compare
// with write back, then a last read and a finish step; the sift loop through
// the RAM sets how many steps. The result becomes valid in the same cycle as
// the sequencer returns to idle and can take the next sample.
// A sample is taken only while the sequencer is idle; it may be taken while
// the previous result still waits in the output register. When the receiver
// stalls, the sequencer holds in its final step until the output register is
// free. Reset empties the heap (fill count zero), sets k_count to 1 and
// order_mode to 0; heap RAM contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module kth_largest_stream_tracker_core #(
  parameter int CAPACITY = kthtrk_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [kthtrk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kthtrk_pkg::CFG_DATA_W-1:0]    cfg_data,
  kthtrk_sample_if.sink                        sample,
  kthtrk_result_if.source                      result
);
  import kthtrk_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam int KW = (CW > KCOUNT_W) ? CW : KCOUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [KCOUNT_W-1:0]   k_count;
  logic                  order_mode;
  logic [CW-1:0]         fill;
  logic [AW-1:0]         pos;
  sample_t               value;
  sample_t               root;
  logic                  out_valid;
  sample_t               out_rank;
  held_t                 out_held;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  sample_t               mem_wdata;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  sample_t               rdata_a;
  sample_t               rdata_b;

  logic [KW-1:0]         k_ext;
  logic [CW-1:0]         k_eff;
  logic [AW-1:0]         parent;
  logic [IW-1:0]         left_i;
  logic [IW-1:0]         right_i;
  logic [IW-1:0]         size_ext;
  logic                  left_ok;
  logic                  right_ok;
  logic                  take_left;
  logic                  take_right;
  sample_t               left_win_val;
  logic                  accept;
  logic                  beats;
  logic                  out_free;

  function automatic logic above(input sample_t a, input sample_t b, input logic mode);
    above = mode ? (a > b) : (a < b);
  endfunction

  kthtrk_heap_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_heap_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign sample.ready      = (state == ST_IDLE);
  assign accept            = sample.valid && sample.ready;
  assign result.valid      = out_valid;
  assign result.rank_value = out_rank;
  assign result.held_count = out_held;
  assign out_free          = !out_valid || result.ready;

  assign k_ext = KW'(k_count);
  always_comb begin
    if (k_ext == '0) begin
      k_eff = CW'(1);
    end else if (k_ext > KW'(CAPACITY)) begin
      k_eff = CW'(CAPACITY);
    end else begin
      k_eff = CW'(k_ext);
    end
  end

  assign beats    = order_mode ? (sample.sample_value < root) : (sample.sample_value > root);
  assign parent   = AW'((pos - AW'(1)) >> 1);
  assign left_i   = IW'({pos, 1'b1});
  assign right_i  = IW'({pos, 1'b0}) + IW'(2);
  assign size_ext = IW'(fill);
  assign left_ok  = left_i < size_ext;
  assign right_ok = right_i < size_ext;

  assign take_left    = left_ok && above(rdata_a, value, order_mode);
  assign left_win_val = take_left ? rdata_a : value;
  assign take_right   = right_ok && above(rdata_b, left_win_val, order_mode);

  always_comb begin
    raddr_a = left_ok ? AW'(left_i) : '0;
    raddr_b = right_ok ? AW'(right_i) : '0;
    if (state == ST_UP_RD) begin
      raddr_a = parent;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = value;
    case (state)
      ST_UP_RD: begin
        mem_we = (pos == '0);
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        if (above(value, rdata_a, order_mode)) begin
          mem_wdata = rdata_a;
        end
      end
      ST_DN_RD: begin
        mem_we = !left_ok;
      end
      ST_DN_CMP: begin
        mem_we = 1'b1;
        if (take_right) begin
          mem_wdata = rdata_b;
        end else if (take_left) begin
          mem_wdata = rdata_a;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == '0) begin
      root <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k_count    <= KCOUNT_W'(1);
      order_mode <= 1'b0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_K_COUNT:    k_count    <= cfg_data;
          REG_ORDER_MODE: order_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (out_valid && result.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            value <= sample.sample_value;
            if (fill < k_eff) begin
              pos   <= AW'(fill);
              fill  <= fill + CW'(1);
              state <= ST_UP_RD;
            end else if (fill != '0 && beats) begin
              pos   <= '0;
              state <= ST_DN_RD;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_UP_RD: begin
          state <= (pos == '0) ? ST_FINISH : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (above(value, rdata_a, order_mode)) begin
            pos   <= parent;
            state <= ST_UP_RD;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_DN_RD: begin
          state <= left_ok ? ST_DN_CMP : ST_FINISH;
        end
        ST_DN_CMP: begin
          if (take_right) begin
            pos   <= AW'(right_i);
            state <= ST_DN_RD;
          end else if (take_left) begin
            pos   <= AW'(left_i);
            state <= ST_DN_RD;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_rank  <= root;
            out_held  <= HELD_W'(fill);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted sample did not start the sequencer");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill != '0)
    else $error("result presented with an empty heap");

  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_FINISH) |-> IW'(pos) < size_ext)
    else $error("sift position outside the held entries");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> out_valid && state == ST_IDLE)
    else $error("finished sample did not reach the output register");

endmodule

/* hdl/kthtrk_heap_ram.sv */
// ----------------------------------------------------------------------------
// kthtrk_heap_ram
// Heap storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kthtrk_heap_ram #(
  parameter int DEPTH = kthtrk_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(kthtrk_pkg::CAPACITY_DEF)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  kthtrk_pkg::sample_t wdata,
  input  logic [AW-1:0]       raddr_a,
  input  logic [AW-1:0]       raddr_b,
  output kthtrk_pkg::sample_t rdata_a,
  output kthtrk_pkg::sample_t rdata_b
);
  import kthtrk_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
